>>> hdl/button_debounce_long_press_core_assert.svh
// ----------------------------------------------------------------------------
// Button debouncer assertion macros
// Shared concurrent assertion forms; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdlp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdlp assertion failed");

`else

`define BDLP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define BDLP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer package
// Field widths, action and register codes, and the lane and result word structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    localparam int ACT_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int RAW_W     = 3;
    localparam int PEND_W    = 3;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [ACT_W-1:0] ACT_TICK       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE_PRESS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TAKE_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 1'd1;

    localparam logic              PRESSED_LEVEL_RESET = 1'b0;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET    = 16'd100;

    typedef struct packed {
        logic              pressed_level;
        logic [HOLD_W-1:0] hold_ticks;
    } t_lane_cfg;

    typedef struct packed {
        logic tick;
        logic take_press;
        logic take_long;
        logic raw;
    } t_lane_cmd;

    typedef struct packed {
        logic taken;
        logic press;
        logic long_hit;
    } t_lane_stat;

    typedef struct packed {
        logic              taken;
        logic [PEND_W-1:0] press_pending;
        logic [PEND_W-1:0] long_pending;
    } t_out_word;

endpackage

`default_nettype wire

>>> hdl/bdlp_ifs.sv
// ----------------------------------------------------------------------------
// Button debouncer channel interfaces
// Command input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_in_if import bdlp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [INDEX_W-1:0] index;
    logic [RAW_W-1:0]   raw_levels;

    modport source (output valid, action, index, raw_levels, input ready);
    modport sink   (input valid, action, index, raw_levels, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              taken;
    logic [PEND_W-1:0] press_pending;
    logic [PEND_W-1:0] long_pending;

    modport source (output valid, taken, press_pending, long_pending, input ready);
    modport sink   (input valid, taken, press_pending, long_pending, output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/button_debounce_long_press_core.sv
// A result word appears in the cycle after its command word is accepted.
// Throughput: one command word per cycle; every button lane updates in that cycle.
// The single output register stalls input only while a held result is not taken.
// Reset (synchronous, active low) sets pressed level 0, hold limit 100, all
// sample histories and stable levels to released, and clears flags and counters.
// ----------------------------------------------------------------------------
// Button debouncer with long-press detection
// Top level: register port, one lane per button, and the result merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_long_press_core_assert.svh"

module button_debounce_long_press_core import bdlp_pkg::*; #(
    parameter int BUTTONS = 3
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdlp_cfg_if.sink    i_cfg,
    bdlp_in_if.sink     i_in,
    bdlp_out_if.source  o_out
);

    // Register port. Writes are always taken; the user must write only while the
    // block is idle, so they never race with a command word; this is not enforced.
    logic              r_pressed_level;
    logic [HOLD_W-1:0] r_hold_ticks;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level <= PRESSED_LEVEL_RESET;
            r_hold_ticks    <= HOLD_TICKS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PRESSED_LEVEL: r_pressed_level <= i_cfg.data[0];
                CFG_HOLD_TICKS:    r_hold_ticks    <= i_cfg.data[HOLD_W-1:0];
                default:           r_hold_ticks    <= r_hold_ticks;
            endcase
        end
    end

    // A command word is accepted when the output register can take its result.
    logic       w_in_ready;
    logic       w_accept;
    logic       w_tick;
    logic       w_take_press;
    logic       w_take_long;
    t_lane_cfg  w_lane_cfg;

    assign i_in.ready   = w_in_ready;
    assign w_accept     = i_in.valid && w_in_ready;
    assign w_tick       = w_accept && (i_in.action == ACT_TICK);
    assign w_take_press = w_accept && (i_in.action == ACT_TAKE_PRESS);
    assign w_take_long  = w_accept && (i_in.action == ACT_TAKE_LONG);

    assign w_lane_cfg.pressed_level = r_pressed_level;
    assign w_lane_cfg.hold_ticks    = r_hold_ticks;

    // One lane per button. A take command reaches only the lane whose number
    // matches the index, so an index past the last button touches nothing.
    // Buttons beyond the raw field always sample a low level.
    logic [BUTTONS-1:0] w_taken_vec;
    logic [BUTTONS-1:0] w_press_vec;
    logic [BUTTONS-1:0] w_long_vec;

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        t_lane_cmd  w_cmd;
        t_lane_stat w_stat;

        assign w_cmd.tick       = w_tick;
        assign w_cmd.take_press = w_take_press && (i_in.index == INDEX_W'(b));
        assign w_cmd.take_long  = w_take_long && (i_in.index == INDEX_W'(b));
        if (b < RAW_W) begin : g_raw
            assign w_cmd.raw = i_in.raw_levels[b];
        end else begin : g_noraw
            assign w_cmd.raw = 1'b0;
        end

        bdlp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_lane_cfg),
            .i_cmd   (w_cmd),
            .o_stat  (w_stat)
        );

        assign w_taken_vec[b] = w_stat.taken;
        assign w_press_vec[b] = w_stat.press;
        assign w_long_vec[b]  = w_stat.long_hit;
    end

    // The merge stage ORs the lane hits into the taken bit and registers the
    // word, so the result is the flag state after this command.
    logic      w_out_valid;
    t_out_word w_out_word;

    bdlp_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_taken_vec (w_taken_vec),
        .i_press_vec (w_press_vec),
        .i_long_vec  (w_long_vec),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_valid     (w_out_valid),
        .o_word      (w_out_word)
    );

    assign o_out.valid         = w_out_valid;
    assign o_out.taken         = w_out_word.taken;
    assign o_out.press_pending = w_out_word.press_pending;
    assign o_out.long_pending  = w_out_word.long_pending;

    // Every accepted command produces a result word in the next cycle.
    `BDLP_ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, w_accept, o_out.valid)
    // A held result that is not taken blocks new commands.
    `BDLP_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    // A sample tick never reports a taken flag.
    `BDLP_ASSERT_NXT(a_tick_not_taken, i_clk, i_rst_n, w_tick, !o_out.taken)

endmodule

`default_nettype wire

>>> hdl/bdlp_lane.sv
// ----------------------------------------------------------------------------
// Button debouncer lane
// Sample history, stable level, sticky flags and hold counter of one button.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_lane import bdlp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_lane_cfg  i_cfg,
    input  wire t_lane_cmd  i_cmd,
    output t_lane_stat      o_stat
);

    // After a shift the oldest sample is the current middle one, so the
    // three-deep history needs only two registers beside the raw input.
    logic              r_newest, r_middle, r_stable, r_press, r_long;
    logic              n_newest, n_middle, n_stable, n_press, n_long;
    logic [HOLD_W-1:0] r_count, n_count;
    logic              w_agree;

    // After the shift the three samples are raw, newest and middle.
    assign w_agree = (i_cmd.raw == r_newest) && (r_newest == r_middle);

    always_comb begin
        n_newest = r_newest;
        n_middle = r_middle;
        n_stable = r_stable;
        n_press  = r_press;
        n_long   = r_long;
        n_count  = r_count;
        if (i_cmd.tick) begin
            n_newest = i_cmd.raw;
            n_middle = r_newest;
            if (w_agree) begin
                if (r_middle != r_stable) begin
                    n_stable = r_middle;
                    if (r_middle == i_cfg.pressed_level) begin
                        n_press = 1'b1;
                    end else begin
                        n_count = '0;
                    end
                end else if ((r_stable == i_cfg.pressed_level) &&
                             (r_count < i_cfg.hold_ticks)) begin
                    n_count = r_count + 16'd1;
                    if (n_count == i_cfg.hold_ticks) begin
                        n_long = 1'b1;
                    end
                end
            end
        end
        if (i_cmd.take_press && r_press) begin
            n_press = 1'b0;
        end
        if (i_cmd.take_long && r_long) begin
            n_long  = 1'b0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= ~PRESSED_LEVEL_RESET;
            r_middle <= ~PRESSED_LEVEL_RESET;
            r_stable <= ~PRESSED_LEVEL_RESET;
            r_press  <= 1'b0;
            r_long   <= 1'b0;
            r_count  <= '0;
        end else begin
            r_newest <= n_newest;
            r_middle <= n_middle;
            r_stable <= n_stable;
            r_press  <= n_press;
            r_long   <= n_long;
            r_count  <= n_count;
        end
    end

    assign o_stat.taken    = (i_cmd.take_press && r_press) || (i_cmd.take_long && r_long);
    assign o_stat.press    = n_press;
    assign o_stat.long_hit = n_long;

endmodule

`default_nettype wire

>>> hdl/bdlp_merge.sv
// ----------------------------------------------------------------------------
// Button debouncer merge stage
// Combines the lane results into one result word held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_merge import bdlp_pkg::*; #(
    parameter int BUTTONS = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [BUTTONS-1:0] i_taken_vec,
    input  wire logic [BUTTONS-1:0] i_press_vec,
    input  wire logic [BUTTONS-1:0] i_long_vec,
    input  wire logic               i_out_ready,
    output logic                    o_in_ready,
    output logic                    o_valid,
    output t_out_word               o_word
);

    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;

    // Only buttons that exist show up in the pending fields.
    for (genvar j = 0; j < PEND_W; j++) begin : g_pend
        if (j < BUTTONS) begin : g_on
            assign n_word.press_pending[j] = i_press_vec[j];
            assign n_word.long_pending[j]  = i_long_vec[j];
        end else begin : g_off
            assign n_word.press_pending[j] = 1'b0;
            assign n_word.long_pending[j]  = 1'b0;
        end
    end
    assign n_word.taken = |i_taken_vec;

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> tb/sv/bdlp_tb_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer scoreboard
// Tracks debounce state, press and long-press flags, and checks result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package bdlp_tb_pkg;

    import bdlp_pkg::*;

    localparam int NBTN = 3;

    // The action encoding leaves one code unused; the block must ignore it.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    class debounce_scoreboard;

        logic              pressed_level;
        logic [HOLD_W-1:0] hold_limit;
        logic [NBTN-1:0]   smp_new;
        logic [NBTN-1:0]   smp_mid;
        logic [NBTN-1:0]   smp_old;
        logic [NBTN-1:0]   stable;
        logic [NBTN-1:0]   press_flags;
        logic [NBTN-1:0]   long_flags;
        logic [HOLD_W-1:0] hold_cnt [NBTN];
        t_out_word         expected_words [$];
        int                errors;

        function new();
            pressed_level = PRESSED_LEVEL_RESET;
            hold_limit    = HOLD_TICKS_RESET;
            smp_new       = pressed_level ? '0 : '1;
            smp_mid       = smp_new;
            smp_old       = smp_new;
            stable        = smp_new;
            press_flags   = '0;
            long_flags    = '0;
            for (int b = 0; b < NBTN; b++) hold_cnt[b] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_PRESSED_LEVEL: pressed_level = data[0];
                CFG_HOLD_TICKS:    hold_limit    = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // Shift the raw levels into the history and update every button.
        function void sample_tick(logic [RAW_W-1:0] raw);
            logic [NBTN-1:0] agree;
            smp_old = smp_mid;
            smp_mid = smp_new;
            smp_new = raw[NBTN-1:0];
            agree   = ~(smp_new ^ smp_mid) & ~(smp_mid ^ smp_old);
            for (int b = 0; b < NBTN; b++) begin
                if (agree[b]) begin
                    if (smp_old[b] != stable[b]) begin
                        stable[b] = smp_old[b];
                        if (stable[b] == pressed_level)
                            press_flags[b] = 1'b1;
                        else
                            hold_cnt[b] = '0;
                    end else if (stable[b] == pressed_level && hold_cnt[b] < hold_limit) begin
                        hold_cnt[b] = hold_cnt[b] + 1'b1;
                        if (hold_cnt[b] == hold_limit)
                            long_flags[b] = 1'b1;
                    end
                end
            end
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [INDEX_W-1:0] idx,
                                   logic [RAW_W-1:0] raw);
            t_out_word w;
            logic      taken;
            taken = 1'b0;
            if (act == ACT_TICK) begin
                sample_tick(raw);
            end else if ((act == ACT_TAKE_PRESS || act == ACT_TAKE_LONG) && idx < NBTN) begin
                if (act == ACT_TAKE_PRESS) begin
                    if (press_flags[idx]) begin
                        press_flags[idx] = 1'b0;
                        taken = 1'b1;
                    end
                end else if (long_flags[idx]) begin
                    long_flags[idx] = 1'b0;
                    hold_cnt[idx]   = '0;
                    taken = 1'b1;
                end
            end
            w.taken         = taken;
            w.press_pending = press_flags;
            w.long_pending  = long_flags;
            expected_words.push_back(w);
        endfunction

        task report(string what, int exp_v, int got_v);
            errors++;
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        endtask

        task check_result(t_out_word got);
            t_out_word w;
            if (expected_words.size() == 0) begin
                report("unexpected result word", 0, 1);
            end else begin
                w = expected_words.pop_front();
                if (got.taken !== w.taken)
                    report("taken", w.taken, got.taken);
                if (got.press_pending !== w.press_pending)
                    report("press_pending", w.press_pending, got.press_pending);
                if (got.long_pending !== w.long_pending)
                    report("long_pending", w.long_pending, got.long_pending);
            end
        endtask

        function int outstanding();
            return expected_words.size();
        endfunction

        task flush_leftover();
            if (expected_words.size() != 0)
                report("words still outstanding", 0, expected_words.size());
        endtask

    endclass

endpackage

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Directed and random command words through the core, with random idling on
// both channels and register changes between phases; every result word is
// checked against a scoreboard that tracks the debounce state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import bdlp_pkg::*;
    import bdlp_tb_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 50;

    logic i_clk;
    logic i_rst_n;

    bdlp_cfg_if cfg_ch ();
    bdlp_in_if  in_ch ();
    bdlp_out_if out_ch ();

    button_debounce_long_press_core #(
        .BUTTONS (NBTN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    debounce_scoreboard sb;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;

    // Raw level each button is meant to sit at; random ticks add bounce on top.
    logic [NBTN-1:0] held_levels;

    // Per-phase register settings. Both polarities and the hold limit extremes
    // (zero, one and the full 16-bit count) are visited.
    logic              phase_level [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [HOLD_W-1:0] phase_hold  [PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd4,
                                              16'd2, 16'd100, 16'd7, 16'd3};

    always #5 i_clk = ~i_clk;

    // The receiver decides at each falling edge whether to take the next word.
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // All handshakes are observed at the rising edge. A result word always
    // belongs to a command accepted at an earlier edge, so the order of the
    // three checks inside this block does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{taken: out_ch.taken, press_pending: out_ch.press_pending,
                                  long_pending: out_ch.long_pending});
            if (in_ch.valid && in_ch.ready)
                sb.note_command(in_ch.action, in_ch.index, in_ch.raw_levels);
        end
    end

    // Register writes only happen while nothing is in flight.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drives one command word from a falling edge and returns at the falling
    // edge after it was accepted. Valid stays high between back-to-back words.
    task send_word(logic [ACT_W-1:0] act, logic [INDEX_W-1:0] idx, logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.action     = act;
        in_ch.index      = idx;
        in_ch.raw_levels = raw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops sending until every expected word has come back, then lets the
    // registered result stage settle before returning.
    task wait_drained();
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Random words are mostly sample ticks that follow slowly changing button
    // levels with occasional bounce, so debouncing, press detection and the
    // hold counter are all exercised. The rest are take requests, mostly for
    // real buttons, plus some out-of-range indexes and the unused action.
    task random_phase(int n, int pause_at);
        int              r;
        logic [RAW_W-1:0] raw;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at)
                wait_drained();
            r = $urandom_range(99);
            if (r < 60) begin
                for (int b = 0; b < NBTN; b++)
                    if ($urandom_range(99) < 12) held_levels[b] = ~held_levels[b];
                raw = held_levels;
                for (int b = 0; b < NBTN; b++)
                    if ($urandom_range(99) < 8) raw[b] = ~raw[b];
                send_word(ACT_TICK, INDEX_W'($urandom_range(15)), raw);
            end else if (r < 95) begin
                send_word(($urandom_range(1) != 0) ? ACT_TAKE_LONG : ACT_TAKE_PRESS,
                          ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(15, NBTN))
                                                   : INDEX_W'($urandom_range(NBTN - 1)),
                          RAW_W'($urandom_range(7)));
            end else begin
                send_word(ACT_UNUSED, INDEX_W'($urandom_range(15)), RAW_W'($urandom_range(7)));
            end
        end
    endtask

    // Hard stop in case a handshake never completes.
    initial begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_PRESSED_LEVEL;
        cfg_ch.data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_TICK;
        in_ch.index      = '0;
        in_ch.raw_levels = '0;
        out_ch.ready     = 1'b1;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        held_levels      = '1;
        sb = new();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: active-low buttons with a hold limit of two ticks.
        write_reg(CFG_PRESSED_LEVEL, CFG_DAT_W'(1'b0));
        write_reg(CFG_HOLD_TICKS, CFG_DAT_W'(2));

        // Takes with the flags still clear return nothing.
        send_word(ACT_TAKE_PRESS, 4'd0, 3'd0);
        send_word(ACT_TAKE_LONG, 4'd2, 3'd7);
        send_word(ACT_TICK, 4'd15, 3'd7);
        // Three agreeing pressed samples set the press flags; two more ticks
        // reach the hold limit and set the long-press flags.
        repeat (5) send_word(ACT_TICK, 4'd0, 3'd0);
        send_word(ACT_TAKE_PRESS, 4'd0, 3'd0);
        send_word(ACT_TAKE_PRESS, 4'd1, 3'd0);
        send_word(ACT_TAKE_PRESS, 4'd2, 3'd0);
        // Out-of-range buttons, including the largest index.
        send_word(ACT_TAKE_PRESS, 4'd15, 3'd7);
        send_word(ACT_TAKE_PRESS, 4'd3, 3'd0);
        // Taking the long press restarts the count, so a held button fires again.
        send_word(ACT_TAKE_LONG, 4'd1, 3'd0);
        repeat (2) send_word(ACT_TICK, 4'd0, 3'd0);
        send_word(ACT_UNUSED, 4'd0, 3'd7);
        send_word(ACT_TAKE_LONG, 4'd1, 3'd0);
        send_word(ACT_TAKE_LONG, 4'd1, 3'd0);
        // A bouncing sample on button one must not break the debounced level.
        send_word(ACT_TICK, 4'd0, 3'd2);
        send_word(ACT_TICK, 4'd0, 3'd0);
        send_word(ACT_TICK, 4'd0, 3'd2);
        // Release everything, then a take with no press pending.
        repeat (3) send_word(ACT_TICK, 4'd0, 3'd7);
        send_word(ACT_TAKE_PRESS, 4'd0, 3'd0);

        // Random phases rotate through the idling patterns: none, sender
        // only, receiver only, and both. The level register flips between
        // phases without touching the state, so its new meaning applies to
        // whatever history is already there.
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            wait_drained();
            write_reg(CFG_PRESSED_LEVEL, CFG_DAT_W'(phase_level[p]));
            write_reg(CFG_HOLD_TICKS, phase_hold[p]);
            case (p % 4)
                1: send_idle_pct = 54;
                2: recv_stall_pct = 54;
                3: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
                default: ;
            endcase
            random_phase(PHASE_WORDS, (p == 3) ? PHASE_WORDS / 2 : -1);
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (5) @(negedge i_clk);
        sb.flush_leftover();

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
